@@ rtl/compass_heading_with_calibration_assert.svh @@
// Assertion macros shared by the compass heading RTL
`ifndef COMPASS_HEADING_WITH_CALIBRATION_ASSERT_SVH
`define COMPASS_HEADING_WITH_CALIBRATION_ASSERT_SVH

// implication checked on every clock edge outside reset
`define CCAL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be seen outside reset
`define CCAL_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

@@ rtl/ccal_pkg.sv @@
package ccal_pkg;

  localparam int FRAC_BITS_DEF    = 15;
  localparam int CORDIC_STEPS_DEF = 16;

  localparam logic [7:0] CAL_COUNT_RST = 8'd100;

  // result status codes
  localparam logic [1:0] STAT_CAL    = 2'd0;
  localparam logic [1:0] STAT_VALID  = 2'd1;
  localparam logic [1:0] STAT_ORIGIN = 2'd2;
  localparam logic [1:0] STAT_ZRANGE = 2'd3;

  typedef struct packed {
    logic signed [15:0] raw_x;
    logic signed [15:0] raw_y;
  } in_item_t;

  typedef struct packed {
    logic [8:0] heading_deg;
    logic [1:0] status;
  } out_item_t;

  // atan(2^-i) in binary-angle units, 2^32 per turn
  function automatic logic [31:0] atan_lut(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/compass_heading_with_calibration.sv @@
// One transaction at a time; the next is accepted in the cycle after the result
// loads. Calibration and zero-range samples finish from the check state, origin
// samples after both divides, and headings after the divides, the iterative CORDIC
// (skipped when an axis is zero) and the quadrant and degree steps. Pace is set by
// the shared bit-serial divider (once per axis), the CORDIC and any output stall.
// Reset (rst_n, synchronous): min/max and sample count clear, calibration count 100.
`include "compass_heading_with_calibration_assert.svh"

module compass_heading_with_calibration #(
  parameter int FRAC_BITS    = ccal_pkg::FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = ccal_pkg::CORDIC_STEPS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ccal_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ccal_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_wdata
);

  localparam int NW = FRAC_BITS + 1;
  localparam int QW = FRAC_BITS + 17;

  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001,
    S_CHK  = 8'b00000010,
    S_DIVX = 8'b00000100,
    S_DIVY = 8'b00001000,
    S_CORD = 8'b00010000,
    S_HDG  = 8'b00100000,
    S_MUL  = 8'b01000000,
    S_DONE = 8'b10000000
  } state_t;

  state_t state_r, state_nxt;

  logic [7:0]         cal_cnt_r;
  logic [7:0]         smp_cnt_r, smp_cnt_nxt;
  logic signed [15:0] x_max_r, x_max_nxt, x_min_r, x_min_nxt;
  logic signed [15:0] y_max_r, y_max_nxt, y_min_r, y_min_nxt;
  ccal_pkg::in_item_t raw_r;
  logic signed [NW-1:0] nx_r, nx_nxt, ny_nxt;
  logic                 ny_neg_r, ny_neg_nxt;
  logic [30:0]          z_r, z_nxt;
  logic [32:0]          h_r, h_nxt;
  ccal_pkg::out_item_t  res_r, res_nxt;
  ccal_pkg::out_item_t  out_data_r;
  logic                 out_valid_r;
  logic                 out_load;

  logic               in_acc;
  logic               calibrating;
  logic [15:0]        x_rng, y_rng;
  logic signed [17:0] cx, cy;
  logic [16:0]        mag_x, mag_y;
  logic               div_start, div_done;
  logic [16:0]        div_mag;
  logic [15:0]        div_dvsr;
  logic [QW-1:0]      div_q;
  logic signed [NW-1:0] div_sat;
  logic               div_neg;
  logic [FRAC_BITS:0] ax, ay;
  logic               cord_start, cord_done;
  logic [30:0]        cord_angle;
  logic [41:0]        prod;
  logic [9:0]         deg;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n)
      cal_cnt_r <= ccal_pkg::CAL_COUNT_RST;
    else if (cfg_we)
      cal_cnt_r <= cfg_wdata;
  end

  // calibration ranges and centred values
  assign calibrating = smp_cnt_r < cal_cnt_r;
  assign x_rng = 16'(17'(x_max_r) - 17'(x_min_r));
  assign y_rng = 16'(17'(y_max_r) - 17'(y_min_r));
  assign cx = (18'(raw_r.raw_x) <<< 1) - (18'(x_max_r) + 18'(x_min_r));
  assign cy = (18'(raw_r.raw_y) <<< 1) - (18'(y_max_r) + 18'(y_min_r));
  assign mag_x = cx[17] ? 17'(-cx) : cx[16:0];
  assign mag_y = cy[17] ? 17'(-cy) : cy[16:0];

  // shared divider: X issued from the check state, Y when X finishes
  assign div_mag  = (state_r == S_CHK) ? mag_x : mag_y;
  assign div_dvsr = (state_r == S_CHK) ? x_rng : y_rng;
  assign div_neg  = (state_r == S_DIVX) ? cx[17] : cy[17];

  ccal_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .mag   (div_mag),
    .dvsr  (div_dvsr),
    .done  (div_done),
    .quot  (div_q)
  );

  // saturate the truncated quotient to Q1.FRAC_BITS
  always_comb begin
    if (div_neg)
      div_sat = (div_q > QW'(1 << FRAC_BITS)) ? NW'(1 << FRAC_BITS) : NW'(-div_q);
    else
      div_sat = (div_q > QW'((1 << FRAC_BITS) - 1)) ? NW'((1 << FRAC_BITS) - 1)
                                                    : NW'(div_q);
  end

  assign ny_nxt = div_sat;
  assign ax = nx_r[NW-1] ? NW'(-nx_r) : NW'(nx_r);
  assign ay = ny_nxt[NW-1] ? NW'(-ny_nxt) : NW'(ny_nxt);

  ccal_cordic #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cord_start),
    .ax    (ax),
    .ay    (ay),
    .done  (cord_done),
    .angle (cord_angle)
  );

  // degrees = floor(h * 360 / 2^32), full turn wraps to zero
  assign prod = 42'(h_r) * 42'(360);
  assign deg  = prod[41:32];

  assign out_load = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    smp_cnt_nxt = smp_cnt_r;
    x_max_nxt   = x_max_r;
    x_min_nxt   = x_min_r;
    y_max_nxt   = y_max_r;
    y_min_nxt   = y_min_r;
    nx_nxt      = nx_r;
    ny_neg_nxt  = ny_neg_r;
    z_nxt       = z_r;
    h_nxt       = h_r;
    res_nxt     = res_r;
    div_start   = 1'b0;
    cord_start  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_acc)
          state_nxt = S_CHK;
      end
      S_CHK: begin
        res_nxt.heading_deg = '0;
        if (calibrating) begin
          if (raw_r.raw_x > x_max_r) x_max_nxt = raw_r.raw_x;
          if (raw_r.raw_x < x_min_r) x_min_nxt = raw_r.raw_x;
          if (raw_r.raw_y > y_max_r) y_max_nxt = raw_r.raw_y;
          if (raw_r.raw_y < y_min_r) y_min_nxt = raw_r.raw_y;
          smp_cnt_nxt    = smp_cnt_r + 8'd1;
          res_nxt.status = ccal_pkg::STAT_CAL;
          state_nxt      = S_DONE;
        end else if (x_rng == '0 || y_rng == '0) begin
          res_nxt.status = ccal_pkg::STAT_ZRANGE;
          state_nxt      = S_DONE;
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIVX;
        end
      end
      S_DIVX: begin
        if (div_done) begin
          nx_nxt    = div_sat;
          div_start = 1'b1;
          state_nxt = S_DIVY;
        end
      end
      S_DIVY: begin
        if (div_done) begin
          ny_neg_nxt = ny_nxt[NW-1];
          if (nx_r == '0 && ny_nxt == '0) begin
            res_nxt.status = ccal_pkg::STAT_ORIGIN;
            state_nxt      = S_DONE;
          end else if (nx_r == '0) begin
            z_nxt     = 31'h40000000;
            state_nxt = S_HDG;
          end else if (ny_nxt == '0) begin
            z_nxt     = '0;
            state_nxt = S_HDG;
          end else begin
            cord_start = 1'b1;
            state_nxt  = S_CORD;
          end
        end
      end
      S_CORD: begin
        if (cord_done) begin
          z_nxt     = cord_angle;
          state_nxt = S_HDG;
        end
      end
      S_HDG: begin
        // quadrant rules
        if (!nx_r[NW-1])
          h_nxt = ny_neg_r ? 33'(34'h100000000 - 34'(z_r)) : 33'(z_r);
        else
          h_nxt = ny_neg_r ? 33'(33'h080000000 + 33'(z_r))
                           : 33'(33'h080000000 - 33'(z_r));
        state_nxt = S_MUL;
      end
      S_MUL: begin
        res_nxt.heading_deg = (deg >= 10'd360) ? 9'd0 : deg[8:0];
        res_nxt.status      = ccal_pkg::STAT_VALID;
        state_nxt           = S_DONE;
      end
      S_DONE: begin
        if (out_load)
          state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    nx_r     <= nx_nxt;
    ny_neg_r <= ny_neg_nxt;
    z_r      <= z_nxt;
    h_r      <= h_nxt;
    res_r    <= res_nxt;
    if (in_acc)
      raw_r <= in_data;
    if (out_load)
      out_data_r <= res_r;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      smp_cnt_r   <= '0;
      x_max_r     <= '0;
      x_min_r     <= '0;
      y_max_r     <= '0;
      y_min_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      smp_cnt_r <= smp_cnt_nxt;
      x_max_r   <= x_max_nxt;
      x_min_r   <= x_min_nxt;
      y_max_r   <= y_max_nxt;
      y_min_r   <= y_min_nxt;
      if (out_load)
        out_valid_r <= 1'b1;
      else if (!out_stall)
        out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `CCAL_ASSERT(a_busy_after_accept, in_acc |=> in_stall, "accepted transaction did not block input")
  `CCAL_NEVER(a_heading_only_valid, out_valid_r && out_data_r.status != ccal_pkg::STAT_VALID && out_data_r.heading_deg != 9'd0, "heading nonzero without valid status")
  `CCAL_NEVER(a_heading_range, out_valid_r && out_data_r.heading_deg >= 9'd360, "heading out of range")
  `CCAL_NEVER(a_minmax_order, x_max_r < x_min_r || y_max_r < y_min_r, "calibration max below min")

endmodule

@@ rtl/ccal_div.sv @@
// Restoring divider, one quotient bit per cycle: q = (mag << FRAC_BITS) / dvsr
module ccal_div #(
  parameter int FRAC_BITS = ccal_pkg::FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [16:0]            mag,
  input  logic [15:0]            dvsr,
  output logic                   done,
  output logic [FRAC_BITS+16:0]  quot
);

  localparam int QW = FRAC_BITS + 17;
  localparam int CW = $clog2(QW + 1);

  logic [QW-1:0] dvd_r, dvd_nxt;
  logic [QW-1:0] q_r, q_nxt;
  logic [16:0]   rem_r, rem_nxt;
  logic [15:0]   dvsr_r, dvsr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [17:0]   trial;
  logic          fits;

  // one trial subtraction per cycle
  assign trial = {rem_r, dvd_r[QW-1]};
  assign fits  = trial >= {2'b00, dvsr_r};

  always_comb begin
    dvd_nxt  = dvd_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvsr_nxt = dvsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      dvd_nxt  = {mag, {FRAC_BITS{1'b0}}};
      rem_nxt  = '0;
      dvsr_nxt = dvsr;
      cnt_nxt  = CW'(QW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[QW-2:0], 1'b0};
      rem_nxt = fits ? 17'(trial - {2'b00, dvsr_r}) : trial[16:0];
      q_nxt   = {q_r[QW-2:0], fits};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    dvd_r  <= dvd_nxt;
    q_r    <= q_nxt;
    rem_r  <= rem_nxt;
    dvsr_r <= dvsr_nxt;
    cnt_r  <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

@@ rtl/ccal_cordic.sv @@
// Vectoring CORDIC, one micro-rotation per cycle, angle clamped to 0..2^30
module ccal_cordic #(
  parameter int FRAC_BITS    = ccal_pkg::FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = ccal_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [FRAC_BITS:0] ax,
  input  logic [FRAC_BITS:0] ay,
  output logic               done,
  output logic [30:0]        angle
);

  localparam int XW = FRAC_BITS + 3;
  localparam int IW = $clog2(CORDIC_STEPS);

  logic signed [XW-1:0] x_r, x_nxt, y_r, y_nxt, dx, dy;
  logic signed [32:0]   z_r, z_nxt, at;
  logic [IW-1:0]        idx_r, idx_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [4:0]           sh;

  assign sh = 5'(idx_r);
  assign dx = y_r >>> sh;
  assign dy = x_r >>> sh;
  assign at = $signed({1'b0, ccal_pkg::atan_lut(sh)});

  always_comb begin
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    idx_nxt  = idx_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      x_nxt    = $signed(XW'(ax));
      y_nxt    = $signed(XW'(ay));
      z_nxt    = '0;
      idx_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // rotate toward the x axis
      if (!y_r[XW-1]) begin
        x_nxt = x_r + dx;
        y_nxt = y_r - dy;
        z_nxt = z_r + at;
      end else begin
        x_nxt = x_r - dx;
        y_nxt = y_r + dy;
        z_nxt = z_r - at;
      end
      idx_nxt = idx_r + IW'(1);
      if (idx_r == IW'(CORDIC_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    z_r   <= z_nxt;
    idx_r <= idx_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // clamp to the first quadrant
  always_comb begin
    if (z_r[32])
      angle = '0;
    else if (z_r > 33'sh040000000)
      angle = 31'h40000000;
    else
      angle = z_r[30:0];
  end

  assign done = done_r;

endmodule
